/* hw/rtl/message_bit_field_extractor_defines.svh */
// Assertion macros shared by the message bit-field extractor modules.
// The macros expect signals named clk and rst_n in the calling module.
`ifndef MESSAGE_BIT_FIELD_EXTRACTOR_DEFINES_SVH
`define MESSAGE_BIT_FIELD_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBFE_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("MBFE assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MBFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("MBFE assertion failed");

`endif

/* hw/rtl/mbfe_pkg.sv */
// Package for the message bit-field extractor: request types, register codes,
// controller states and the command and status structs. No dependencies.
package mbfe_pkg;

  localparam int MAX_FIELD_BYTES_DEF = 32;
  localparam int BYTE_W = 8;
  localparam int BIDX_W = 7;
  localparam int LEN_W = 9;
  localparam int POS_W = 8;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [BIDX_W-1:0] BIDX_MAX = {BIDX_W{1'b1}};

  localparam logic [1:0] REG_PASSTHROUGH = 2'd0;
  localparam logic [1:0] REG_BIT_POSITION = 2'd1;
  localparam logic [1:0] REG_FIELD_LENGTH = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_message;
  } in_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
  } out_req_t;

  typedef struct packed {
    logic             passthrough_mode;
    logic [POS_W-1:0] bit_position;
    logic [LEN_W-1:0] field_length_bits;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic take;
    logic fetch;
    logic load_field;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic emit_go;
    logic last_k;
  } sts_t;

endpackage

/* hw/rtl/message_bit_field_extractor.sv */
// Message bytes enter one per request. In passthrough mode each byte leaves
// unchanged, one byte per cycle while the output is not stalled. In extract mode
// the byte that completes the field starts an emission of ceil(length/8) bytes,
// each made of a buffer read and then a load of the output register, during
// which input requests stall. The field buffer is a memory with no reset
// and needs no clearing pass. Configuration sits on an APB port at byte
// addresses 0 (passthrough), 4 (bit position) and 8 (field length).
module message_bit_field_extractor
  import mbfe_pkg::*;
#(
  parameter int MAX_FIELD_BYTES = MAX_FIELD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_req_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_req_t          out_req,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;
  logic wr_req;

  assign pready = 1'b1;
  assign wr_req = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.passthrough_mode <= 1'b0;
      cfg_r.bit_position <= '0;
      cfg_r.field_length_bits <= LEN_W'(8);
    end else if (wr_req) begin
      case (paddr[3:2])
        REG_PASSTHROUGH: cfg_r.passthrough_mode <= pwdata[0];
        REG_BIT_POSITION: cfg_r.bit_position <= pwdata[POS_W-1:0];
        REG_FIELD_LENGTH: cfg_r.field_length_bits <= pwdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PASSTHROUGH: prdata = {{(DATA_W-1){1'b0}}, cfg_r.passthrough_mode};
      REG_BIT_POSITION: prdata = {{(DATA_W-POS_W){1'b0}}, cfg_r.bit_position};
      REG_FIELD_LENGTH: prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_r.field_length_bits};
      default: prdata = '0;
    endcase
  end

  mbfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mbfe_dp #(
    .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_req   (out_req),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* hw/rtl/mbfe_ctrl.sv */
// Controller state machine of the message bit-field extractor.
// Depends on mbfe_pkg and the shared assertion macro header.
`include "message_bit_field_extractor_defines.svh"

module mbfe_ctrl
  import mbfe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = !sts.out_free;
        cmd.take = in_valid && sts.out_free;
        if (cmd.take && sts.emit_go) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load_field = 1'b1;
          if (sts.last_k) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.step = 1'b1;
            state_nxt = ST_FETCH;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `MBFE_ASSERT_NEXT(a_start_emit, cmd.take && sts.emit_go, state_r == ST_FETCH)
  `MBFE_ASSERT_NEXT(a_fetch_then_load, state_r == ST_FETCH, state_r == ST_LOAD)
  `MBFE_ASSERT_NEXT(a_load_continue,
                    state_r == ST_LOAD && sts.out_free && !sts.last_k,
                    state_r == ST_FETCH)

endmodule

/* hw/rtl/mbfe_dp.sv */
// Datapath of the message bit-field extractor: message position, field buffer,
// bit alignment and the output register. Depends on mbfe_pkg and the macro header.
`include "message_bit_field_extractor_defines.svh"

module mbfe_dp
  import mbfe_pkg::*;
#(
  parameter int MAX_FIELD_BYTES = MAX_FIELD_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  in_req_t  in_data,
  input  logic     out_stall,
  output logic     out_valid,
  output out_req_t out_req,
  input  cmd_t     cmd,
  output sts_t     sts
);

  localparam int AW = $clog2(MAX_FIELD_BYTES + 1);
  localparam int DEPTH = MAX_FIELD_BYTES + 1;
  localparam logic [9:0] MAX_BITS = 10'(MAX_FIELD_BYTES * 8);
  localparam logic [BIDX_W-1:0] MAX_REL = BIDX_W'(MAX_FIELD_BYTES);

  logic [BYTE_W-1:0] mem [DEPTH];

  logic [BIDX_W-1:0] byte_index_r;
  logic              field_done_r;
  logic [BIDX_W-1:0] k_r;
  logic [2:0]        shift_r;
  logic [2:0]        tail_r;
  logic [BIDX_W-1:0] span_r;
  logic [BIDX_W-1:0] nbytes_r;
  logic [BYTE_W-1:0] rd_lo_r;
  logic [BYTE_W-1:0] rd_hi_r;
  logic              out_valid_r;
  out_req_t          out_req_r;

  logic [LEN_W-1:0]  len_cl;
  logic [9:0]        end_bit;
  logic [BIDX_W-1:0] first;
  logic [BIDX_W-1:0] last;
  logic [BIDX_W-1:0] rel;
  logic [9:0]        nb_sum;
  logic              extract;
  logic              wr_en;
  logic [AW-1:0]     rd_a0;
  logic [AW-1:0]     rd_a1;
  logic              hi_ok;
  logic [15:0]       pair;
  logic [BYTE_W-1:0] aligned;
  logic [BYTE_W-1:0] field_byte;

  always_comb begin
    len_cl = ({1'b0, cfg.field_length_bits} > MAX_BITS) ? MAX_BITS[LEN_W-1:0]
                                                        : cfg.field_length_bits;
    end_bit = {2'b00, cfg.bit_position} + {1'b0, len_cl} - 10'd1;
    first = {2'b00, cfg.bit_position[7:3]};
    last = end_bit[9:3];
    rel = byte_index_r - first;
    nb_sum = {1'b0, len_cl} + 10'd7;
    extract = !cfg.passthrough_mode && (len_cl != '0) && !field_done_r;
    wr_en = cmd.take && extract && (byte_index_r >= first) && (rel <= MAX_REL);
    sts.emit_go = extract && (byte_index_r == last);
    sts.out_free = !out_valid_r || !out_stall;
    sts.last_k = (k_r + 1'b1) == nbytes_r;
    rd_a0 = k_r[AW-1:0];
    rd_a1 = AW'(k_r + 1'b1);
    hi_ok = (shift_r != 3'd0) && ((k_r + 1'b1) <= span_r);
    pair = {(hi_ok ? rd_hi_r : 8'h00), rd_lo_r} >> shift_r;
    aligned = pair[7:0];
    field_byte = aligned;
    if (sts.last_k && tail_r != 3'd0) begin
      field_byte = aligned & ((8'd1 << tail_r) - 8'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[rel[AW-1:0]] <= in_data.data_byte;
    end
    if (cmd.fetch) begin
      rd_lo_r <= mem[rd_a0];
      rd_hi_r <= mem[rd_a1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && sts.emit_go) begin
      shift_r <= cfg.bit_position[2:0];
      tail_r <= len_cl[2:0];
      span_r <= last - first;
      nbytes_r <= nb_sum[9:3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= '0;
      field_done_r <= 1'b0;
      k_r <= '0;
    end else begin
      if (cmd.take) begin
        if (in_data.end_of_message) begin
          byte_index_r <= '0;
          field_done_r <= 1'b0;
        end else begin
          if (byte_index_r != BIDX_MAX) begin
            byte_index_r <= byte_index_r + 1'b1;
          end
          if (sts.emit_go) begin
            field_done_r <= 1'b1;
          end
        end
        if (sts.emit_go) begin
          k_r <= '0;
        end
      end else if (cmd.step) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.take && cfg.passthrough_mode) begin
      out_valid_r <= 1'b1;
    end else if (cmd.load_field) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && cfg.passthrough_mode) begin
      out_req_r.out_byte <= in_data.data_byte;
      out_req_r.last_of_run <= in_data.end_of_message;
    end else if (cmd.load_field) begin
      out_req_r.out_byte <= field_byte;
      out_req_r.last_of_run <= sts.last_k;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req = out_req_r;

  `MBFE_ASSERT_NEXT(a_pass_loads_out, cmd.take && cfg.passthrough_mode, out_valid_r)
  `MBFE_ASSERT_NEXT(a_field_loads_out, cmd.load_field, out_valid_r)
  `MBFE_ASSERT(a_emit_in_buffer, cmd.take && sts.emit_go, rel <= MAX_REL)

endmodule
